### sv/mstk_pkg.sv
package mstk_pkg;

    localparam int unsigned STACK_DEPTH = 64;
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ENTRY_W = 7;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
    localparam logic signed [DATA_W-1:0] EMPTY_MIN = -32'sd1;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY_POP = 2'd1,
        ST_FULL_PUSH = 2'd2
    } t_status;

    typedef struct packed {
        t_action                  action;
        logic signed [DATA_W-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic signed [DATA_W-1:0] min_value;
        logic                     min_valid;
        logic [ENTRY_W-1:0]       entry_count;
        t_status                  status;
    } t_rsp;

endpackage

### sv/min_tracking_stack_unit.sv
// Each transaction is accepted when start is high and busy is low.
// An accepted transaction passes through the busy state; the result strobe o_valid is registered from it.
// A new transaction cannot be accepted while busy, which waits for the registered read of the stack RAMs.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous active-low reset empties both stacks; RAM contents are not cleared.
module min_tracking_stack_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  mstk_pkg::t_req i_req,
    output logic           busy,
    output logic           o_valid,
    output mstk_pkg::t_rsp o_result
);

    import mstk_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_vcnt, n_vcnt;
    logic [CNT_W-1:0]         r_mcnt, n_mcnt;
    logic signed [DATA_W-1:0] r_vtop, n_vtop;
    logic signed [DATA_W-1:0] r_mtop, n_mtop;
    logic                     r_pop_v, n_pop_v;
    logic                     r_pop_m, n_pop_m;
    logic signed [DATA_W-1:0] r_popped, n_popped;
    t_status                  r_status, n_status;
    logic                     r_valid, n_valid;
    t_rsp                     r_result, n_result;

    logic              v_we;
    logic              m_we;
    logic [ADDR_W-1:0] v_rsum;
    logic [ADDR_W-1:0] m_rsum;
    logic [DATA_W-1:0] v_rdata;
    logic [DATA_W-1:0] m_rdata;

    assign v_rsum = r_vcnt[ADDR_W-1:0] - ADDR_W'(2);
    assign m_rsum = r_mcnt[ADDR_W-1:0] - ADDR_W'(2);

    mstk_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (v_we),
        .i_waddr(r_vcnt[ADDR_W-1:0]),
        .i_wdata(i_req.push_value),
        .i_raddr(v_rsum),
        .o_rdata(v_rdata)
    );

    mstk_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_min_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(r_mcnt[ADDR_W-1:0]),
        .i_wdata(i_req.push_value),
        .i_raddr(m_rsum),
        .o_rdata(m_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_vcnt   = r_vcnt;
        n_mcnt   = r_mcnt;
        n_vtop   = r_vtop;
        n_mtop   = r_mtop;
        n_pop_v  = r_pop_v;
        n_pop_m  = r_pop_m;
        n_popped = r_popped;
        n_status = r_status;
        n_valid  = 1'b0;
        n_result = r_result;
        v_we     = 1'b0;
        m_we     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state  = S_BUSY;
                    n_pop_v  = 1'b0;
                    n_pop_m  = 1'b0;
                    n_popped = '0;
                    n_status = ST_OK;
                    if (i_req.action == ACT_PUSH) begin
                        if (r_vcnt == DEPTH_CNT) begin
                            n_status = ST_FULL_PUSH;
                        end else begin
                            v_we   = 1'b1;
                            n_vcnt = r_vcnt + CNT_W'(1);
                            n_vtop = i_req.push_value;
                            if (r_mcnt != DEPTH_CNT && (r_mcnt == '0 ||
                                    $signed(i_req.push_value) <= r_mtop)) begin
                                m_we   = 1'b1;
                                n_mcnt = r_mcnt + CNT_W'(1);
                                n_mtop = i_req.push_value;
                            end
                        end
                    end else begin
                        if (r_vcnt == '0) begin
                            n_status = ST_EMPTY_POP;
                        end else begin
                            n_vcnt   = r_vcnt - CNT_W'(1);
                            n_popped = r_vtop;
                            n_pop_v  = 1'b1;
                            if (r_mcnt != '0 && r_mtop == r_vtop) begin
                                n_mcnt  = r_mcnt - CNT_W'(1);
                                n_pop_m = 1'b1;
                            end
                        end
                    end
                end
            end
            S_BUSY: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                if (r_pop_v) begin
                    n_vtop = $signed(v_rdata);
                end
                if (r_pop_m) begin
                    n_mtop = $signed(m_rdata);
                end
                n_result.popped_value = r_popped;
                n_result.min_valid    = (r_vcnt != '0) && (r_mcnt != '0);
                n_result.min_value    = n_result.min_valid ? n_mtop : EMPTY_MIN;
                n_result.entry_count  = ENTRY_W'(r_vcnt);
                n_result.status       = r_status;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt  <= '0;
            r_mcnt  <= '0;
            r_pop_v <= 1'b0;
            r_pop_m <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vcnt  <= n_vcnt;
            r_mcnt  <= n_mcnt;
            r_pop_v <= n_pop_v;
            r_pop_m <= n_pop_m;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vtop   <= n_vtop;
        r_mtop   <= n_mtop;
        r_popped <= n_popped;
        r_status <= n_status;
        r_result <= n_result;
    end

    assign busy     = (r_state == S_BUSY);
    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not enter the busy cycle");

    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("busy cycle not followed by a result strobe");

    a_min_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcnt <= r_vcnt)
        else $error("minimum stack deeper than value stack");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= DEPTH_CNT)
        else $error("value count beyond stack depth");

    a_min_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.min_valid) |-> (o_result.entry_count != '0))
        else $error("minimum flagged valid on an empty stack");
`endif

endmodule

### sv/mstk_ram.sv
module mstk_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
